// File: rtl/core/escape_time_fractal_iterator_core_assert.svh
// Assertion macros for the escape-time fractal iterator core.
`ifndef ESCAPE_TIME_FRACTAL_ITERATOR_CORE_ASSERT_SVH
`define ESCAPE_TIME_FRACTAL_ITERATOR_CORE_ASSERT_SVH
`ifndef NO_ASSERTIONS
`define ETF_ASSERT_SAME(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("etf same-cycle check failed");
`define ETF_ASSERT_NEXT(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("etf next-cycle check failed");
`else
`define ETF_ASSERT_SAME(label, ante, cons)
`define ETF_ASSERT_NEXT(label, ante, cons)
`endif
`endif

// File: rtl/core/etf_pkg.sv
// Types, constants and fixed-point helpers for the escape-time fractal iterator.
package etf_pkg;

	localparam int COORD_WIDTH   = 32;
	localparam int FRACTION_BITS = 28;
	localparam int COUNT_WIDTH   = 16;
	localparam int EXP_WIDTH     = 3;
	localparam int CFG_IDX_WIDTH = 3;

	typedef logic signed [COORD_WIDTH-1:0]   coord_t;
	typedef logic signed [2*COORD_WIDTH-1:0] prod_t;
	typedef logic [COUNT_WIDTH-1:0]          count_t;
	typedef logic [EXP_WIDTH-1:0]            exp_t;
	typedef logic [CFG_IDX_WIDTH-1:0]        cfg_idx_t;

	localparam cfg_idx_t REG_FRACTAL_MODE   = 3'd0;
	localparam cfg_idx_t REG_POWER_EXPONENT = 3'd1;
	localparam cfg_idx_t REG_MAX_ITERATIONS = 3'd2;
	localparam cfg_idx_t REG_JULIA_REAL     = 3'd3;
	localparam cfg_idx_t REG_JULIA_IMAG     = 3'd4;

	localparam exp_t   EXP_MIN      = 3'd2;
	localparam exp_t   EXP_MAX      = 3'd6;
	localparam exp_t   EXP_RESET    = 3'd2;
	localparam count_t ITER_RESET   = 16'd1000;

	localparam coord_t FX_MAX  = {1'b0, {(COORD_WIDTH-1){1'b1}}};
	localparam coord_t FX_MIN  = {1'b1, {(COORD_WIDTH-1){1'b0}}};
	localparam coord_t FX_FOUR = coord_t'(3'd4) << FRACTION_BITS;

	// exact product -> truncate magnitude toward zero -> saturate
	function automatic coord_t fx_scale(prod_t p);
		prod_t  sh;
		coord_t r;
		sh = p >>> FRACTION_BITS;
		if (p[2*COORD_WIDTH-1] && (p[FRACTION_BITS-1:0] != '0)) begin
			sh = sh + prod_t'(1);
		end
		if (sh > prod_t'(FX_MAX)) begin
			r = FX_MAX;
		end else if (sh < prod_t'(FX_MIN)) begin
			r = FX_MIN;
		end else begin
			r = sh[COORD_WIDTH-1:0];
		end
		return r;
	endfunction

	function automatic coord_t fx_addsub(coord_t a, coord_t b, logic sub);
		logic [COORD_WIDTH:0] s;
		coord_t               r;
		if (sub) begin
			s = {a[COORD_WIDTH-1], a} - {b[COORD_WIDTH-1], b};
		end else begin
			s = {a[COORD_WIDTH-1], a} + {b[COORD_WIDTH-1], b};
		end
		if (s[COORD_WIDTH] != s[COORD_WIDTH-1]) begin
			r = s[COORD_WIDTH] ? FX_MIN : FX_MAX;
		end else begin
			r = s[COORD_WIDTH-1:0];
		end
		return r;
	endfunction

endpackage

// File: rtl/core/escape_time_fractal_iterator_core.sv
// Escape-time fractal iterator core: one shared multiplier and saturating adder under a sequencer.
// Per iteration: |z|^2, then n-1 complex multiplies, then + c.
// A point ends on escape after k iterations or when k reaches the limit;
// n = exponent (2 in Julia mode).
// One point at a time; busy stays high until the result strobe, the next start is taken then.
// Result is shown for one cycle with done; the receiver cannot stall.
// arst_n clears control state and loads register defaults (Mandelbrot, n=2, limit 1000).
module escape_time_fractal_iterator_core (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       start,
	output logic                       busy,
	input  etf_pkg::coord_t            point_real,
	input  etf_pkg::coord_t            point_imag,
	input  logic                       cfg_valid,
	output logic                       cfg_ready,
	input  etf_pkg::cfg_idx_t          cfg_index,
	input  logic [etf_pkg::COORD_WIDTH-1:0] cfg_data,
	output logic                       done,
	output etf_pkg::count_t            iteration_count,
	output logic                       inside_set
);

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_MAG,
		ST_CMUL,
		ST_ADD
	} state_t;

	state_t            state_q;
	logic [2:0]        step_q;
	etf_pkg::exp_t     n_q;
	etf_pkg::exp_t     e_q;
	etf_pkg::count_t   cnt_q;
	etf_pkg::coord_t   zr_q, zi_q, wr_q, wi_q, cr_q, ci_q, t_q, re_q;
	etf_pkg::prod_t    prod_q;

	logic              mode_q;
	etf_pkg::exp_t     exp_q;
	etf_pkg::count_t   max_q;
	etf_pkg::coord_t   jr_q, ji_q;

	etf_pkg::coord_t   mul_a, mul_b, add_a, add_b, fx_prod, sum;
	logic              add_sub;
	etf_pkg::exp_t     n_eff;

	assign busy      = (state_q != ST_IDLE);
	assign cfg_ready = 1'b1;

	// configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q <= 1'b0;
			exp_q  <= etf_pkg::EXP_RESET;
			max_q  <= etf_pkg::ITER_RESET;
			jr_q   <= '0;
			ji_q   <= '0;
		end else if (cfg_valid && cfg_ready) begin
			unique case (cfg_index)
				etf_pkg::REG_FRACTAL_MODE:   mode_q <= cfg_data[0];
				etf_pkg::REG_POWER_EXPONENT: exp_q  <= cfg_data[etf_pkg::EXP_WIDTH-1:0];
				etf_pkg::REG_MAX_ITERATIONS: max_q  <= cfg_data[etf_pkg::COUNT_WIDTH-1:0];
				etf_pkg::REG_JULIA_REAL:     jr_q   <= cfg_data;
				etf_pkg::REG_JULIA_IMAG:     ji_q   <= cfg_data;
				default: ;
			endcase
		end
	end

	always_comb begin
		if (mode_q) begin
			n_eff = etf_pkg::EXP_MIN;
		end else if (exp_q < etf_pkg::EXP_MIN) begin
			n_eff = etf_pkg::EXP_MIN;
		end else if (exp_q > etf_pkg::EXP_MAX) begin
			n_eff = etf_pkg::EXP_MAX;
		end else begin
			n_eff = exp_q;
		end
	end

	// operand select for the shared multiplier and adder
	always_comb begin
		mul_a   = zr_q;
		mul_b   = zr_q;
		add_a   = t_q;
		add_b   = fx_prod;
		add_sub = 1'b0;
		unique case (state_q)
			ST_MAG: begin
				if (step_q[0]) begin
					mul_a = zi_q;
					mul_b = zi_q;
				end
			end
			ST_CMUL: begin
				case (step_q)
					3'd0: begin
						mul_a = wr_q;
						mul_b = zr_q;
					end
					3'd1: begin
						mul_a = wi_q;
						mul_b = zi_q;
					end
					3'd2: begin
						mul_a   = wr_q;
						mul_b   = zi_q;
						add_sub = 1'b1;
					end
					3'd3: begin
						mul_a = wi_q;
						mul_b = zr_q;
					end
					default: ;
				endcase
			end
			ST_ADD: begin
				add_a = step_q[0] ? wi_q : wr_q;
				add_b = step_q[0] ? ci_q : cr_q;
			end
			default: ;
		endcase
	end

	always_ff @(posedge clk) begin
		prod_q <= etf_pkg::prod_t'(mul_a) * etf_pkg::prod_t'(mul_b);
	end

	assign fx_prod = etf_pkg::fx_scale(prod_q);
	assign sum     = etf_pkg::fx_addsub(add_a, add_b, add_sub);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q         <= ST_IDLE;
			step_q          <= '0;
			n_q             <= etf_pkg::EXP_MIN;
			e_q             <= '0;
			cnt_q           <= '0;
			zr_q            <= '0;
			zi_q            <= '0;
			wr_q            <= '0;
			wi_q            <= '0;
			cr_q            <= '0;
			ci_q            <= '0;
			t_q             <= '0;
			re_q            <= '0;
			done            <= 1'b0;
			iteration_count <= '0;
			inside_set      <= 1'b0;
		end else begin
			done <= 1'b0;
			unique case (state_q)
				ST_IDLE: begin
					if (start) begin
						state_q <= ST_MAG;
						step_q  <= '0;
						cnt_q   <= '0;
						n_q     <= n_eff;
						if (mode_q) begin
							zr_q <= point_real;
							zi_q <= point_imag;
							cr_q <= jr_q;
							ci_q <= ji_q;
						end else begin
							zr_q <= '0;
							zi_q <= '0;
							cr_q <= point_real;
							ci_q <= point_imag;
						end
					end
				end
				ST_MAG: begin
					case (step_q)
						3'd0: begin
							if (cnt_q == max_q) begin
								state_q         <= ST_IDLE;
								done            <= 1'b1;
								iteration_count <= cnt_q;
								inside_set      <= 1'b1;
							end else begin
								step_q <= 3'd1;
							end
						end
						3'd1: begin
							t_q    <= fx_prod;
							step_q <= 3'd2;
						end
						default: begin
							if (sum > etf_pkg::FX_FOUR) begin
								state_q         <= ST_IDLE;
								done            <= 1'b1;
								iteration_count <= cnt_q;
								inside_set      <= 1'b0;
							end else begin
								state_q <= ST_CMUL;
								step_q  <= '0;
								e_q     <= etf_pkg::exp_t'(1);
								wr_q    <= zr_q;
								wi_q    <= zi_q;
							end
						end
					endcase
				end
				ST_CMUL: begin
					case (step_q)
						3'd0: step_q <= 3'd1;
						3'd1: begin
							t_q    <= fx_prod;
							step_q <= 3'd2;
						end
						3'd2: begin
							re_q   <= sum;
							step_q <= 3'd3;
						end
						3'd3: begin
							t_q    <= fx_prod;
							step_q <= 3'd4;
						end
						default: begin
							wr_q   <= re_q;
							wi_q   <= sum;
							step_q <= '0;
							if (e_q == n_q - etf_pkg::exp_t'(1)) begin
								state_q <= ST_ADD;
							end else begin
								e_q <= e_q + etf_pkg::exp_t'(1);
							end
						end
					endcase
				end
				ST_ADD: begin
					if (step_q[0]) begin
						zi_q    <= sum;
						cnt_q   <= cnt_q + etf_pkg::count_t'(1);
						state_q <= ST_MAG;
						step_q  <= '0;
					end else begin
						zr_q   <= sum;
						step_q <= 3'd1;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

`include "escape_time_fractal_iterator_core_assert.svh"

	`ETF_ASSERT_SAME(a_inside_at_limit, done && inside_set, iteration_count == max_q)
	`ETF_ASSERT_SAME(a_count_bounded, busy, cnt_q <= max_q)
	`ETF_ASSERT_NEXT(a_start_goes_busy, start && !busy, busy)
	`ETF_ASSERT_SAME(a_done_when_idle, done, !busy)

endmodule
